// ===== rtl/core/fre_pkg.sv =====
// Shared types, constants and address helper for the frame store rectangle engine.
package fre_pkg;

   localparam int WIDTH       = 256;
   localparam int HEIGHT      = 64;
   localparam int DEPTH       = WIDTH * HEIGHT;
   localparam int X_BITS      = $clog2(WIDTH);
   localparam int Y_BITS      = $clog2(HEIGHT);
   localparam int ADDR_BITS   = $clog2(DEPTH);
   localparam int COORD_BITS  = 12;
   localparam int DIFF_BITS   = COORD_BITS + 2;
   localparam int PIXEL_BITS  = 8;
   localparam int BORDER_BITS = 8;

   localparam logic signed [COORD_BITS-1:0] X_MAX = COORD_BITS'(WIDTH - 1);
   localparam logic signed [COORD_BITS-1:0] Y_MAX = COORD_BITS'(HEIGHT - 1);
   localparam logic [ADDR_BITS-1:0] ROW_STRIDE = ADDR_BITS'(WIDTH);
   localparam logic [ADDR_BITS-1:0] LAST_ADDR  = ADDR_BITS'(DEPTH - 1);

   typedef enum logic [1:0] {
      ACT_SET  = 2'd0,
      ACT_GET  = 2'd1,
      ACT_RECT = 2'd2
   } action_type;

   // Rectangle with corners in order and its scan window clipped to the store.
   typedef struct packed {
      logic signed [COORD_BITS-1:0] x1;
      logic signed [COORD_BITS-1:0] y1;
      logic signed [COORD_BITS-1:0] x2;
      logic signed [COORD_BITS-1:0] y2;
      logic [BORDER_BITS-1:0]       bw;
      logic                         filled;
      logic [X_BITS-1:0]            lx;
      logic [X_BITS-1:0]            hx;
      logic [Y_BITS-1:0]            ly;
      logic [Y_BITS-1:0]            hy;
      logic [PIXEL_BITS-1:0]        color;
   } rect_type;

   typedef struct packed {
      logic                  we;
      logic [ADDR_BITS-1:0]  addr;
      logic [PIXEL_BITS-1:0] data;
   } pix_type;

   function automatic logic [ADDR_BITS-1:0] pix_addr(input logic [Y_BITS-1:0] y,
                                                     input logic [X_BITS-1:0] x);
      logic [ADDR_BITS-1:0] row;
      row = ADDR_BITS'(y) * ROW_STRIDE;
      return row + ADDR_BITS'(x);
   endfunction

endpackage

// ===== rtl/core/fre_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module fre_ram #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = 16,
   localparam int ADDR_W   = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/fre_raster.sv =====
// Rectangle scanner: walks the clipped window one pixel per cycle and issues writes.
module fre_raster import fre_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  rect_type rect,
   output pix_type  pix,
   output logic     last
);

   logic                 busy_ff;
   rect_type             rect_ff;
   logic [X_BITS-1:0]    x_ff;
   logic [Y_BITS-1:0]    y_ff;
   logic [ADDR_BITS-1:0] base_ff;

   logic signed [DIFF_BITS-1:0] xs, ys, x1s, y1s, x2s, y2s, bws;
   logic                        on_border;
   logic                        row_end;

   always_comb begin
      xs  = DIFF_BITS'(x_ff);
      ys  = DIFF_BITS'(y_ff);
      x1s = DIFF_BITS'(rect_ff.x1);
      y1s = DIFF_BITS'(rect_ff.y1);
      x2s = DIFF_BITS'(rect_ff.x2);
      y2s = DIFF_BITS'(rect_ff.y2);
      bws = DIFF_BITS'(rect_ff.bw);
      on_border = ((xs - x1s) < bws) || ((x2s - xs) < bws) ||
                  ((ys - y1s) < bws) || ((y2s - ys) < bws);
   end

   assign row_end  = (x_ff == rect_ff.hx);
   assign last     = busy_ff && row_end && (y_ff == rect_ff.hy);
   assign pix.we   = busy_ff && (rect_ff.filled || on_border);
   assign pix.addr = base_ff + ADDR_BITS'(x_ff);
   assign pix.data = rect_ff.color;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         rect_ff <= rect;
         x_ff    <= rect.lx;
         y_ff    <= rect.ly;
         base_ff <= pix_addr(rect.ly, '0);
      end else if (busy_ff) begin
         if (row_end) begin
            x_ff <= rect_ff.lx;
            if (y_ff == rect_ff.hy) begin
               busy_ff <= 1'b0;
            end else begin
               y_ff    <= y_ff + 1'b1;
               base_ff <= base_ff + ROW_STRIDE;
            end
         end else begin
            x_ff <= x_ff + 1'b1;
         end
      end
   end

endmodule

// ===== rtl/core/framebuffer_rect_fill_engine.sv =====
// A set pixel writes the store as it is accepted; a get pixel waits for the registered RAM read;
// a draw rectangle walks every pixel of the rectangle clipped to the store, one pixel a cycle,
// since the single RAM write port takes one pixel a cycle.
// One command is in progress at a time; the engine is idle again as rsp_valid rises, so the next
// is taken also while that result waits. After reset the store is cleared one pixel per cycle,
// all WIDTH*HEIGHT = 16384 pixels, during which req_ready stays low.
module framebuffer_rect_fill_engine import fre_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_action,
   input  logic signed [COORD_BITS-1:0] req_first_x,
   input  logic signed [COORD_BITS-1:0] req_first_y,
   input  logic signed [COORD_BITS-1:0] req_second_x,
   input  logic signed [COORD_BITS-1:0] req_second_y,
   input  logic [BORDER_BITS-1:0]       req_border_width,
   input  logic [PIXEL_BITS-1:0]        req_color,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [PIXEL_BITS-1:0]        rsp_pixel_value
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SETUP,
      ST_DRAW,
      ST_DONE
   } state_type;

   state_type                    state_ff;
   logic [ADDR_BITS-1:0]         clr_ff;
   logic signed [COORD_BITS-1:0] fx_ff, fy_ff, sx_ff, sy_ff;
   logic [BORDER_BITS-1:0]       bw_ff;
   logic [PIXEL_BITS-1:0]        color_ff;
   logic                         inb_ff;
   logic [PIXEL_BITS-1:0]        result_ff;
   logic                         rsp_valid_ff;
   logic [PIXEL_BITS-1:0]        rsp_value_ff;

   logic                  accept;
   action_type            act;
   logic                  req_in_store;
   logic [ADDR_BITS-1:0]  req_addr;
   logic                  out_free;

   logic                  wr_en, rd_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [PIXEL_BITS-1:0] wr_data, rd_data;

   rect_type              rect;
   logic                  rect_empty;
   logic                  raster_start, raster_last;
   pix_type               pix;

   logic signed [COORD_BITS-1:0] x1, y1, x2, y2;
   logic signed [DIFF_BITS-1:0]  bws;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign act       = action_type'(req_action);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign req_in_store = (req_first_x >= 0) && (req_first_x <= X_MAX) &&
                         (req_first_y >= 0) && (req_first_y <= Y_MAX);
   assign req_addr = pix_addr(req_first_y[Y_BITS-1:0], req_first_x[X_BITS-1:0]);

   // Put corners in order, clip the scan window and decide filled versus border.
   always_comb begin
      x1  = (fx_ff <= sx_ff) ? fx_ff : sx_ff;
      x2  = (fx_ff <= sx_ff) ? sx_ff : fx_ff;
      y1  = (fy_ff <= sy_ff) ? fy_ff : sy_ff;
      y2  = (fy_ff <= sy_ff) ? sy_ff : fy_ff;
      bws = DIFF_BITS'(bw_ff);
      rect.x1     = x1;
      rect.y1     = y1;
      rect.x2     = x2;
      rect.y2     = y2;
      rect.bw     = bw_ff;
      rect.color  = color_ff;
      rect.filled = (bw_ff == '0) ||
                    (bws > (DIFF_BITS'(x2) - DIFF_BITS'(x1))) ||
                    (bws > (DIFF_BITS'(y2) - DIFF_BITS'(y1)));
      rect.lx = (x1 < 0) ? '0 : x1[X_BITS-1:0];
      rect.hx = (x2 > X_MAX) ? X_MAX[X_BITS-1:0] : x2[X_BITS-1:0];
      rect.ly = (y1 < 0) ? '0 : y1[Y_BITS-1:0];
      rect.hy = (y2 > Y_MAX) ? Y_MAX[Y_BITS-1:0] : y2[Y_BITS-1:0];
      rect_empty = (x1 > X_MAX) || (x2 < 0) || (y1 > Y_MAX) || (y2 < 0);
   end

   assign raster_start = (state_ff == ST_SETUP) && !rect_empty;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = req_addr;
      wr_data = req_color;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
         end
         ST_IDLE: begin
            wr_en = accept && (act == ACT_SET) && req_in_store;
         end
         ST_DRAW: begin
            wr_en   = pix.we;
            wr_addr = pix.addr;
            wr_data = pix.data;
         end
         default: begin
         end
      endcase
   end

   assign rd_en = accept && (act == ACT_GET);

   fre_ram #(
      .DATA_BITS(PIXEL_BITS),
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(req_addr),
      .rd_data(rd_data)
   );

   fre_raster u_raster (
      .clock(clock),
      .reset(reset),
      .start(raster_start),
      .rect(rect),
      .pix(pix),
      .last(raster_last)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // In ST_DONE the result register is reloaded below instead.
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == LAST_ADDR) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  fx_ff    <= req_first_x;
                  fy_ff    <= req_first_y;
                  sx_ff    <= req_second_x;
                  sy_ff    <= req_second_y;
                  bw_ff    <= req_border_width;
                  color_ff <= req_color;
                  unique case (act)
                     ACT_GET: begin
                        inb_ff   <= req_in_store;
                        state_ff <= ST_READ;
                     end
                     ACT_RECT: begin
                        state_ff <= ST_SETUP;
                     end
                     default: begin
                        result_ff <= '0;
                        state_ff  <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_READ: begin
               result_ff <= inb_ff ? rd_data : '0;
               state_ff  <= ST_DONE;
            end
            ST_SETUP: begin
               result_ff <= '0;
               state_ff  <= rect_empty ? ST_DONE : ST_DRAW;
            end
            ST_DRAW: begin
               if (raster_last) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= result_ff;
                  state_ff     <= ST_IDLE;
               end else begin
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_value_ff;

endmodule

// ===== rtl/core/fre_checker.sv =====
// Port-level checker for the frame store rectangle engine, bound to the top level.
module fre_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_pixel_value
);

   // A stalled result transaction keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_value))
      else $error("result changed while stalled");

   // The store is being cleared right after reset, so no command is taken.
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("command taken during the clearing pass");

   // Only one command is in progress at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second command taken while one is in progress");

endmodule

bind framebuffer_rect_fill_engine fre_checker u_fre_checker (.*);
